@@ sv/gf2_64_inverse_macros.svh @@
// Assertion macros shared by the GF(2^64) inverter.
`ifndef GF2_64_INVERSE_MACROS_SVH
`define GF2_64_INVERSE_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define GF64I_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define GF64I_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/gf64i_pkg.sv @@
// Shared types, constants and helper functions of the GF(2^64) inverter.
`timescale 1ns / 1ps
`default_nettype none

package gf64i_pkg;

    localparam logic [63:0] POLY_LOW      = 64'h1B;
    localparam int          POLY_DEG      = 64;
    localparam int          DEF_MAX_STEPS = 128;
    localparam int          DEG_W         = 8;

    // Degree of a word: -1 for zero, else position of the top set bit.
    typedef logic signed [DEG_W-1:0] t_deg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_STEP,
        S_NORM
    } t_state;

    typedef struct packed {
        logic load;     // take a new operand
        logic deg_r1;   // recompute degree of r1
        logic step;     // swap if needed, then shifted XOR
        logic deg_r0;   // recompute degree of r0
        logic finish;   // register the result and strobe it
    } t_cmd;

    typedef struct packed {
        logic r1_fin;   // r1 is 0 or 1
    } t_sts;

    function automatic t_deg word_degree(input logic [63:0] v);
        t_deg d;
        d = -8'sd1;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                d = t_deg'(i);
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ sv/gf64i_ctrl.sv @@
// Sequencer of the GF(2^64) inverter: loads, alternates step and degree phases, finishes.
`timescale 1ns / 1ps
`default_nettype none

module gf64i_ctrl import gf64i_pkg::*; #(
    parameter int MAX_STEPS = DEF_MAX_STEPS
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  start,
    output logic busy,
    input  wire t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int CNT_W = $clog2(MAX_STEPS + 1);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        busy    = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.deg_r1 = 1'b1;
                if (i_sts.r1_fin) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + CNT_W'(1);
                n_state    = S_NORM;
            end
            S_NORM: begin
                o_cmd.deg_r0 = 1'b1;
                if (i_sts.r1_fin || (r_cnt == CNT_W'(MAX_STEPS))) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_STEP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/gf64i_dp.sv @@
// Datapath of the GF(2^64) inverter: remainder and cofactor pairs, degrees, result register.
`timescale 1ns / 1ps
`default_nettype none

module gf64i_dp import gf64i_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire  [63:0] i_operand,
    input  wire t_cmd   i_cmd,
    output t_sts        o_sts,
    output logic [63:0] o_inverse,
    output logic        o_valid
);

    logic [63:0] r_r0, r_r1, r_s0, r_s1, r_inverse;
    t_deg        r_d0, r_d1;
    logic        r_valid;

    logic        swap;
    logic [63:0] a_r0, a_r1, a_s0, a_s1;
    t_deg        a_d0, a_d1;
    logic [8:0]  sh;
    logic        sh_ok;
    logic [63:0] sh_r1, sh_s1;

    // Swap so that r0 has the larger degree; the shift is then never negative.
    always_comb begin
        swap  = (r_d0 < r_d1);
        a_r0  = swap ? r_r1 : r_r0;
        a_r1  = swap ? r_r0 : r_r1;
        a_s0  = swap ? r_s1 : r_s0;
        a_s1  = swap ? r_s0 : r_s1;
        a_d0  = swap ? r_d1 : r_d0;
        a_d1  = swap ? r_d0 : r_d1;
        sh    = {a_d0[DEG_W-1], a_d0} - {a_d1[DEG_W-1], a_d1};
        // A shift of 64 or more drops the whole term.
        sh_ok = (sh[8:6] == 3'b000);
        sh_r1 = sh_ok ? (a_r1 << sh[5:0]) : 64'd0;
        sh_s1 = sh_ok ? (a_s1 << sh[5:0]) : 64'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r0 <= POLY_LOW;
            r_r1 <= i_operand;
            r_s0 <= 64'd0;
            r_s1 <= 64'd1;
            r_d0 <= t_deg'(POLY_DEG);
        end else if (i_cmd.step) begin
            r_r0 <= a_r0 ^ sh_r1;
            r_r1 <= a_r1;
            r_s0 <= a_s0 ^ sh_s1;
            r_s1 <= a_s1;
            r_d0 <= a_d0;
            r_d1 <= a_d1;
        end else begin
            if (i_cmd.deg_r0) begin
                r_d0 <= word_degree(r_r0);
            end
            if (i_cmd.deg_r1) begin
                r_d1 <= word_degree(r_r1);
            end
        end
        if (i_cmd.finish) begin
            r_inverse <= (r_r1 == 64'd0) ? 64'd0 : r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    assign o_sts.r1_fin = (r_r1[63:1] == 63'd0);
    assign o_inverse    = r_inverse;
    assign o_valid      = r_valid;

endmodule

`default_nettype wire

@@ sv/gf2_64_inverse.sv @@
// Top level of the GF(2^64) inverter by binary extended Euclid.
//
//   port group            dir   width  meaning
//   start / busy          in    1      beat accepted when start is high and busy is low
//   i_operand             in    64     element to invert
//   o_valid / o_inverse   out   1/64   one-cycle strobe with the inverse
//
// The accept cycle loads the pairs, a degree phase then finds the degree of the operand,
// and each Euclid step is a swap and shifted XOR followed by the
// leading-one search on r0. An item runs at most MAX_STEPS steps; operands 0
// and 1 take none and leave busy after the degree phase.
// The result strobes in the first cycle with busy low again. Reset is
// synchronous and clears the sequencer and the strobe. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "gf2_64_inverse_macros.svh"

module gf2_64_inverse import gf64i_pkg::*; #(
    parameter int MAX_STEPS = DEF_MAX_STEPS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [63:0] i_operand,
    output logic        o_valid,
    output logic [63:0] o_inverse
);

    t_cmd s_cmd;
    t_sts s_sts;

    gf64i_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd)
    );

    gf64i_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_operand (i_operand),
        .i_cmd     (s_cmd),
        .o_sts     (s_sts),
        .o_inverse (o_inverse),
        .o_valid   (o_valid)
    );

    // A result only follows the end of an item, so the block is idle then.
    `GF64I_ASSERT_NOW(a_valid_idle, i_clk, i_rst_n, o_valid, !busy, "result while busy")
    // An accepted beat always occupies the block in the next cycle.
    `GF64I_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept lost")
    // Results never come back to back, since the sequencer is idle when a result strobes.
    `GF64I_ASSERT_NEXT(a_valid_gap, i_clk, i_rst_n, o_valid, !o_valid, "double result")
    // A finish command only comes while the item is being worked on.
    `GF64I_ASSERT_NOW(a_finish_busy, i_clk, i_rst_n, s_cmd.finish, busy && !s_cmd.load,
        "finish outside an item")

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the GF(2^64) inverter: directed and random operands.
`timescale 1ns / 1ps

class inverse_board;
    logic [63:0] pending_inverses[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    // Position of the leading one, or -1 for a zero word.
    static function int lead_one(logic [63:0] v);
        int pos;
        pos = -1;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                pos = i;
            end
        end
        return pos;
    endfunction

    static function logic [63:0] shifted_or_zero(logic [63:0] v, int sh);
        if (sh < 0 || sh > 63) begin
            return 64'd0;
        end
        return v << sh;
    endfunction

    // Binary extended Euclid against x^64 + x^4 + x^3 + x + 1.
    // The x^64 term of the modulus is implicit, so the first XOR into the
    // low word clears it without ever being stored.
    static function logic [63:0] field_inverse(logic [63:0] a);
        logic [63:0] rem_hi, rem_lo, cof_hi, cof_lo, tmp;
        int          deg_hi, deg_lo, tdeg, sh;
        bit          done;
        rem_hi = 64'h1B;
        rem_lo = a;
        cof_hi = 64'd0;
        cof_lo = 64'd1;
        deg_hi = 64;
        deg_lo = lead_one(a);
        done   = (a == 64'd0) || (a == 64'd1);
        for (int n = 0; n < 128 && !done; n++) begin
            if (deg_hi < deg_lo) begin
                tmp = rem_hi; rem_hi = rem_lo; rem_lo = tmp;
                tmp = cof_hi; cof_hi = cof_lo; cof_lo = tmp;
                tdeg = deg_hi; deg_hi = deg_lo; deg_lo = tdeg;
            end
            sh     = deg_hi - deg_lo;
            rem_hi = rem_hi ^ shifted_or_zero(rem_lo, sh);
            cof_hi = cof_hi ^ shifted_or_zero(cof_lo, sh);
            deg_hi = lead_one(rem_hi);
            if (rem_lo == 64'd0 || rem_lo == 64'd1) begin
                done = 1'b1;
            end
        end
        return (rem_lo == 64'd0) ? 64'd0 : cof_lo;
    endfunction

    function void note_operand(logic [63:0] op);
        pending_inverses.push_back(field_inverse(op));
    endfunction

    function void check_inverse(logic [63:0] got);
        logic [63:0] want;
        if (pending_inverses.size() == 0) begin
            $display("%0t unexpected result beat: inverse expected none actual %h",
                     $time, got);
            errors++;
            return;
        end
        want = pending_inverses.pop_front();
        if (got !== want) begin
            $display("%0t mismatch: inverse expected %h actual %h", $time, want, got);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [63:0] i_operand;
    logic        o_valid;
    logic [63:0] o_inverse;

    inverse_board board = new();
    bit           burst;

    gf2_64_inverse u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_operand (i_operand),
        .o_valid   (o_valid),
        .o_inverse (o_inverse)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver cannot stall, so every strobe is a result beat.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            board.check_inverse(o_inverse);
        end
    end

    // Presents one operand after a random gap and returns once it is taken.
    task automatic send_operand(input logic [63:0] op);
        int gap;
        if ($urandom_range(0, 15) == 0) begin
            burst = !burst;
        end
        gap = burst ? 0 : $urandom_range(0, 13);
        @(negedge i_clk);
        if (gap > 0) begin
            start     <= 1'b0;
            i_operand <= {$urandom, $urandom};
            repeat (gap) @(negedge i_clk);
        end
        start     <= 1'b1;
        i_operand <= op;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        board.note_operand(op);
    endtask

    function automatic logic [63:0] random_operand();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: begin
                v = 64'd0;
                repeat ($urandom_range(1, 4)) v[$urandom_range(0, 63)] = 1'b1;
            end
            1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            2: v = 64'(($urandom_range(0, 7) == 0) ? 1 : 0);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    initial begin
        logic [63:0] corner_ops[$];
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_operand = 64'd0;
        burst     = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero and unit skip the loop; the rest stress long and short runs.
        corner_ops = '{64'd0, 64'd1, 64'd2, 64'd3, 64'h1B, 64'h1A,
                       64'h8000_0000_0000_0000, 64'h8000_0000_0000_001B,
                       64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                       64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                       64'h0000_0001_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                       64'h4000_0000_0000_0000, 64'h0123_4567_89AB_CDEF,
                       64'h0000_0000_0000_00FF, 64'hF000_0000_0000_000F,
                       64'd1, 64'd0};
        foreach (corner_ops[k]) begin
            send_operand(corner_ops[k]);
        end

        repeat (1600) begin
            send_operand(random_operand());
        end
        @(negedge i_clk);
        start <= 1'b0;

        while (board.pending_inverses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
